/* sv/ipc_pkg.sv */
`default_nettype none

package ipc_pkg;

   localparam int MAX_NETS       = 4;
   localparam int DEF_NUM_NETS   = 4;
   localparam int DEF_HOST_BITS  = 8;
   localparam int CSR_INDEX_W    = 3;
   localparam int DATA_W         = 32;
   localparam int PREFIX_W       = 6;
   localparam int ADDR_BITS      = 32;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam logic [2:0]  NO_NET         = 3'd4;
   localparam logic        FUNC_PACKET    = 1'b0;
   localparam logic        FUNC_READ      = 1'b1;
   // csr_index[0] selects base or prefix, csr_index[2:1] the network
   localparam logic        CSR_KIND_BASE   = 1'b0;
   localparam logic        CSR_KIND_PREFIX = 1'b1;

   typedef struct packed {
      logic        func;
      logic [15:0] ether_type;
      logic [3:0]  ip_version;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] ip_length;
      logic [1:0]  read_net;
      logic [7:0]  read_host;
   } req_type;

   typedef struct packed {
      logic [2:0]  src_net;
      logic [2:0]  dst_net;
      logic [31:0] in_bytes;
      logic [31:0] out_bytes;
   } rsp_type;

   typedef struct packed {
      logic capture;     // register the accepted item
      logic match_step;  // match networks, read total entries
      logic tot_step;    // update totals, read host entries
      logic host_step;   // update host entries
      logic load_rsp;    // move result into the output register
      logic clr;         // clear one store entry
   } cmd_type;

   typedef struct packed {
      logic clr_last;
   } status_type;

endpackage

`default_nettype wire

/* sv/ipc_ctrl.sv */
`default_nettype none

module ipc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output ipc_pkg::cmd_type     cmd,
   input  ipc_pkg::status_type  status
);
   import ipc_pkg::*;

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      MATCH,
      TOT,
      HOST,
      HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.clr        = (state_ff == CLEAR);
      cmd.capture    = (state_ff == IDLE) && req_valid;
      cmd.match_step = (state_ff == MATCH);
      cmd.tot_step   = (state_ff == TOT);
      cmd.host_step  = (state_ff == HOST);
      cmd.load_rsp   = ((state_ff == HOST) || (state_ff == HOLD)) && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CLEAR: if (status.clr_last) state_in = IDLE;
         IDLE:  if (req_valid) state_in = MATCH;
         MATCH: state_in = TOT;
         TOT:   state_in = HOST;
         HOST:  state_in = slot_free ? IDLE : HOLD;
         HOLD:  if (slot_free) state_in = IDLE;
         default: state_in = CLEAR;
      endcase
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending beat");
   a_capture_then_match: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.match_step)
      else $error("match step did not follow capture");
   a_tot_then_host: assert property (@(posedge clock) disable iff (reset)
      cmd.tot_step |=> cmd.host_step)
      else $error("host step did not follow total step");
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> !rsp_valid_ff)
      else $error("result pending during store clear");
`endif

endmodule

`default_nettype wire

/* sv/ipc_datapath.sv */
`default_nettype none

module ipc_datapath #(
   parameter int NUM_NETS  = ipc_pkg::DEF_NUM_NETS,
   parameter int HOST_BITS = ipc_pkg::DEF_HOST_BITS
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  ipc_pkg::req_type                      req_data,
   output ipc_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_we,
   input  wire  [ipc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [ipc_pkg::DATA_W-1:0]            csr_data,
   input  ipc_pkg::cmd_type                      cmd,
   output ipc_pkg::status_type                   status
);
   import ipc_pkg::*;

   localparam int NET_W      = (NUM_NETS > 1) ? $clog2(NUM_NETS) : 1;
   localparam int AW         = NET_W + HOST_BITS;
   localparam int DEPTH      = NUM_NETS << HOST_BITS;
   localparam int MIN_PREFIX = ADDR_BITS - HOST_BITS;

   logic [31:0]         base_ff   [MAX_NETS];
   logic [PREFIX_W-1:0] prefix_ff [MAX_NETS];

   logic [31:0] out_mem [DEPTH];
   logic [31:0] in_mem  [DEPTH];

   req_type             item_ff;
   rsp_type             rsp_ff;
   logic [2:0]          src_net_ff, dst_net_ff;
   logic [HOST_BITS-1:0] src_host_ff, dst_host_ff;
   logic                read_ok_ff;
   logic [31:0]         rd_in_ff, rd_out_ff;
   logic [31:0]         out_rd_ff, in_rd_ff;
   logic [AW-1:0]       clr_addr_ff;

   logic [31:0]          mask_c [NUM_NETS];
   logic [NUM_NETS-1:0]  en_c, src_hit_c, dst_hit_c;
   logic [2:0]           src_net_c, dst_net_c;
   logic [HOST_BITS-1:0] src_host_c, dst_host_c;
   logic                 pkt_ok_c, read_ok_c, is_read;
   logic [AW-1:0]        rd_idx_c;
   logic [AW-1:0]        out_ra, in_ra, out_wa, in_wa;
   logic                 out_we, in_we;
   logic [31:0]          out_wd, in_wd, len_c, len2_c;

   function automatic logic [AW-1:0] entry_addr(input logic [2:0] net,
                                                input logic [HOST_BITS-1:0] host);
      entry_addr = {net[NET_W-1:0], host};
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < MAX_NETS; n++) begin
            base_ff[n]   <= '0;
            prefix_ff[n] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index[0] == CSR_KIND_BASE) begin
            base_ff[csr_index[2:1]] <= csr_data;
         end else begin
            prefix_ff[csr_index[2:1]] <= csr_data[PREFIX_W-1:0];
         end
      end
   end

   // network match, lowest index wins
   always_comb begin
      for (int n = 0; n < NUM_NETS; n++) begin
         en_c[n]   = (prefix_ff[n] <= PREFIX_W'(ADDR_BITS)) &&
                     (prefix_ff[n] >= PREFIX_W'(MIN_PREFIX));
         mask_c[n] = 32'hFFFF_FFFF << (PREFIX_W'(ADDR_BITS) - prefix_ff[n]);
         src_hit_c[n] = en_c[n] && ((item_ff.src_addr & mask_c[n]) == base_ff[n]);
         dst_hit_c[n] = en_c[n] && ((item_ff.dst_addr & mask_c[n]) == base_ff[n]);
      end
      src_net_c  = NO_NET;
      dst_net_c  = NO_NET;
      src_host_c = '0;
      dst_host_c = '0;
      for (int n = NUM_NETS - 1; n >= 0; n--) begin
         if (src_hit_c[n]) begin
            src_net_c  = 3'(n);
            src_host_c = HOST_BITS'(item_ff.src_addr & ~mask_c[n]);
         end
         if (dst_hit_c[n]) begin
            dst_net_c  = 3'(n);
            dst_host_c = HOST_BITS'(item_ff.dst_addr & ~mask_c[n]);
         end
      end
   end

   assign is_read   = (item_ff.func == FUNC_READ);
   assign pkt_ok_c  = (item_ff.func == FUNC_PACKET) &&
                      (item_ff.ether_type == ETHERTYPE_IPV4) &&
                      (item_ff.ip_version == IP_VERSION_4);
   assign read_ok_c = (32'(item_ff.read_net) < 32'(NUM_NETS)) &&
                      ((32'(item_ff.read_host) >> HOST_BITS) == 32'd0);
   assign rd_idx_c  = entry_addr(3'(item_ff.read_net), HOST_BITS'(item_ff.read_host));
   assign len_c     = 32'(item_ff.ip_length);
   assign len2_c    = 32'(item_ff.ip_length) << 1;

   // read addresses: match step totals or read entry, total step hosts
   always_comb begin
      if (cmd.tot_step) begin
         out_ra = entry_addr(src_net_ff, src_host_ff);
         in_ra  = entry_addr(dst_net_ff, dst_host_ff);
      end else if (is_read) begin
         out_ra = rd_idx_c;
         in_ra  = rd_idx_c;
      end else begin
         out_ra = entry_addr(src_net_c, '0);
         in_ra  = entry_addr(dst_net_c, '0);
      end
   end

   // writes; a zero host part folds both adds into the total entry
   always_comb begin
      out_we = 1'b0;
      in_we  = 1'b0;
      out_wa = entry_addr(src_net_ff, '0);
      in_wa  = entry_addr(dst_net_ff, '0);
      out_wd = out_rd_ff + ((src_host_ff == '0) ? len2_c : len_c);
      in_wd  = in_rd_ff + ((dst_host_ff == '0) ? len2_c : len_c);
      if (cmd.clr) begin
         out_we = 1'b1;
         in_we  = 1'b1;
         out_wa = clr_addr_ff;
         in_wa  = clr_addr_ff;
         out_wd = '0;
         in_wd  = '0;
      end else if (cmd.tot_step) begin
         if (is_read) begin
            out_we = read_ok_ff;
            in_we  = read_ok_ff;
            out_wa = rd_idx_c;
            in_wa  = rd_idx_c;
            out_wd = '0;
            in_wd  = '0;
         end else begin
            out_we = (src_net_ff != NO_NET);
            in_we  = (dst_net_ff != NO_NET);
         end
      end else if (cmd.host_step) begin
         out_we = (src_net_ff != NO_NET) && (src_host_ff != '0);
         in_we  = (dst_net_ff != NO_NET) && (dst_host_ff != '0);
         out_wa = entry_addr(src_net_ff, src_host_ff);
         in_wa  = entry_addr(dst_net_ff, dst_host_ff);
         out_wd = out_rd_ff + len_c;
         in_wd  = in_rd_ff + len_c;
      end
   end

   always_ff @(posedge clock) begin
      if (out_we) out_mem[out_wa] <= out_wd;
      if (in_we)  in_mem[in_wa]   <= in_wd;
      out_rd_ff <= out_mem[out_ra];
      in_rd_ff  <= in_mem[in_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign status.clr_last = (clr_addr_ff == AW'(DEPTH - 1));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.match_step) begin
         src_net_ff  <= pkt_ok_c ? src_net_c : NO_NET;
         dst_net_ff  <= pkt_ok_c ? dst_net_c : NO_NET;
         src_host_ff <= src_host_c;
         dst_host_ff <= dst_host_c;
         read_ok_ff  <= is_read && read_ok_c;
      end
      if (cmd.tot_step) begin
         rd_in_ff  <= read_ok_ff ? in_rd_ff : '0;
         rd_out_ff <= read_ok_ff ? out_rd_ff : '0;
      end
      if (cmd.load_rsp) begin
         rsp_ff.src_net   <= src_net_ff;
         rsp_ff.dst_net   <= dst_net_ff;
         rsp_ff.in_bytes  <= rd_in_ff;
         rsp_ff.out_bytes <= rd_out_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* sv/ip_prefix_traffic_counter.sv */
// channel  | direction | handshake           | beat
// req_     | in        | req_valid/req_stall | ipc_pkg::req_type
// rsp_     | out       | rsp_valid/rsp_stall | ipc_pkg::rsp_type
// csr_     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One item at a time: accept, match, total update, host update, then the result
// beat loads into the output register; the read-modify-write passes over the two
// single-write-port counter memories hold off the next item until the last is done.
// After reset the counter store is swept clear, one entry per cycle over all
// NUM_NETS << HOST_BITS entries (1024 by default); req_stall stays high meanwhile.
// A stalled result holds the block after its host step; csr writes are always taken.
`default_nettype none

module ip_prefix_traffic_counter #(
   parameter int NUM_NETS  = ipc_pkg::DEF_NUM_NETS,
   parameter int HOST_BITS = ipc_pkg::DEF_HOST_BITS
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  ipc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output ipc_pkg::rsp_type                 rsp_data,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [ipc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [ipc_pkg::DATA_W-1:0]       csr_data
);
   import ipc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ipc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ipc_datapath #(
      .NUM_NETS  (NUM_NETS),
      .HOST_BITS (HOST_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import ipc_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int STUCK_LIMIT    = 6000;
   localparam int MAX_SHOWN      = 10;
   localparam int MIN_PREFIX     = ADDR_BITS - DEF_HOST_BITS;
   localparam int FIRST_CFG_ROW  = 2;
   localparam int HOLD_CYCLES    = 60;
   localparam int DRAIN_CYCLES   = 16;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_data;

   ip_prefix_traffic_counter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // local copy of the block state
   logic [31:0] cfg_base [MAX_NETS];
   logic [5:0]  cfg_prefix [MAX_NETS];
   logic [31:0] in_bytes_store [MAX_NETS << DEF_HOST_BITS];
   logic [31:0] out_bytes_store [MAX_NETS << DEF_HOST_BITS];
   logic [31:0] next_base [MAX_NETS];
   logic [5:0]  next_prefix [MAX_NETS];

   rsp_type counts_due [$];
   int      mismatches;
   int      stuck_cycles;
   bit      calm;
   bit      hold_req;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type fixed;
   } dir_row_type;

   dir_row_type dir_rows [$];

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [2:0] match_net(input logic [31:0] addr,
                                            output logic [7:0] host);
      logic [31:0] mask;
      int          n;
      host = '0;
      for (n = 0; n < MAX_NETS; n++) begin
         if (cfg_prefix[n] >= MIN_PREFIX && cfg_prefix[n] <= ADDR_BITS) begin
            mask = 32'hFFFF_FFFF << (ADDR_BITS - cfg_prefix[n]);
            if ((addr & mask) == cfg_base[n]) begin
               host = addr[7:0] & ~mask[7:0];
               return n[2:0];
            end
         end
      end
      return NO_NET;
   endfunction

   // updates the counter copy and returns the result beat for one request beat
   function automatic rsp_type account_beat(input req_type beat);
      rsp_type    res;
      logic [7:0] host;
      logic [9:0] entry;
      res = '0;
      res.src_net = NO_NET;
      res.dst_net = NO_NET;
      if (beat.func == FUNC_READ) begin
         entry = {beat.read_net, beat.read_host};
         res.in_bytes  = in_bytes_store[entry];
         res.out_bytes = out_bytes_store[entry];
         in_bytes_store[entry]  = '0;
         out_bytes_store[entry] = '0;
      end else if (beat.ether_type == ETHERTYPE_IPV4 && beat.ip_version == IP_VERSION_4) begin
         res.src_net = match_net(beat.src_addr, host);
         if (res.src_net != NO_NET) begin
            // host zero lands on the total entry a second time
            out_bytes_store[{res.src_net[1:0], 8'h00}] += 32'(beat.ip_length);
            out_bytes_store[{res.src_net[1:0], host}]  += 32'(beat.ip_length);
         end
         res.dst_net = match_net(beat.dst_addr, host);
         if (res.dst_net != NO_NET) begin
            in_bytes_store[{res.dst_net[1:0], 8'h00}] += 32'(beat.ip_length);
            in_bytes_store[{res.dst_net[1:0], host}]  += 32'(beat.ip_length);
         end
      end
      return res;
   endfunction

   function automatic logic [31:0] pick_host();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'd255;
         2: return $urandom_range(1, 3);
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic logic [31:0] addr_in_net(input int n);
      logic [31:0] mask;
      mask = 32'hFFFF_FF00;
      if (cfg_prefix[n] >= MIN_PREFIX && cfg_prefix[n] <= ADDR_BITS)
         mask = 32'hFFFF_FFFF << (ADDR_BITS - cfg_prefix[n]);
      return cfg_base[n] | (pick_host() & ~mask);
   endfunction

   function automatic req_type random_beat();
      req_type b;
      int      roll;
      b.func       = FUNC_PACKET;
      b.ether_type = 16'($urandom);
      b.ip_version = 4'($urandom);
      b.src_addr   = $urandom;
      b.dst_addr   = $urandom;
      b.ip_length  = 16'($urandom_range(0, 1) ? $urandom_range(0, 1500)
                                             : $urandom_range(0, 65535));
      b.read_net   = 2'($urandom);
      b.read_host  = 8'(pick_host());
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
         b.func = FUNC_READ;
      end else if (roll < 90) begin
         b.ether_type = ETHERTYPE_IPV4;
         b.ip_version = IP_VERSION_4;
         if ($urandom_range(0, 3) != 0)
            b.src_addr = addr_in_net($urandom_range(0, MAX_NETS - 1));
         if ($urandom_range(0, 3) != 0)
            b.dst_addr = addr_in_net($urandom_range(0, MAX_NETS - 1));
      end else if (roll < 95) begin
         // right ethertype, mostly wrong version
         b.ether_type = ETHERTYPE_IPV4;
         b.src_addr   = addr_in_net($urandom_range(0, MAX_NETS - 1));
      end
      return b;
   endfunction

   function automatic void add_row(input logic fn, input logic [15:0] et, input logic [3:0] ver,
                                   input logic [31:0] src, input logic [31:0] dst,
                                   input logic [15:0] len, input logic [1:0] rnet,
                                   input logic [7:0] rhost, input bit typed,
                                   input logic [2:0] sn, input logic [2:0] dn,
                                   input logic [31:0] ib, input logic [31:0] ob);
      dir_row_type row;
      row.beat  = {fn, et, ver, src, dst, len, rnet, rhost};
      row.typed = typed;
      row.fixed = {sn, dn, ib, ob};
      dir_rows.push_back(row);
   endfunction

   task automatic offer_beat(input req_type beat, input bit typed, input rsp_type fixed);
      rsp_type due;
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall !== 1'b0);
      due = account_beat(beat);
      if (typed)
         due = fixed;
      counts_due.push_back(due);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx[0] == CSR_KIND_PREFIX)
         cfg_prefix[idx[2:1]] = data[PREFIX_W-1:0];
      else
         cfg_base[idx[2:1]] = data;
   endtask

   // registers change only with nothing in flight
   task automatic apply_setting();
      int n;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (counts_due.size() == 0);
      repeat (8) @(posedge clock);
      for (n = 0; n < MAX_NETS; n++) begin
         write_csr({n[1:0], CSR_KIND_BASE}, next_base[n]);
         write_csr({n[1:0], CSR_KIND_PREFIX}, {26'd0, next_prefix[n]});
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_setting();
      int n;
      for (n = 0; n < MAX_NETS; n++) begin
         if ($urandom_range(0, 5) == 0) begin
            next_prefix[n] = 6'($urandom_range(0, 63));
            next_base[n]   = $urandom;
         end else begin
            next_prefix[n] = 6'($urandom_range(MIN_PREFIX, ADDR_BITS));
            next_base[n]   = $urandom & (32'hFFFF_FFFF << (ADDR_BITS - next_prefix[n]));
         end
      end
      apply_setting();
   endtask

   task automatic run_random(input int goal, input int hold_at, input int pause_at);
      int      done;
      req_type b;
      done = 0;
      while (done < goal) begin
         b = random_beat();
         offer_beat(b, 1'b0, '0);
         done++;
         if (done == hold_at)
            hold_req = 1'b1;
         if (done == pause_at) begin
            @(negedge clock);
            req_valid <= 1'b0;
            wait (counts_due.size() == 0);
         end
      end
   endtask

   // result side: random stall, one long hold when asked
   always begin
      @(negedge clock);
      if (hold_req) begin
         hold_req = 1'b0;
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 24);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout with %0d results outstanding", counts_due.size());
            $display("tb failed");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (counts_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("unexpected result beat %p", rsp_data);
            end else begin
               want = counts_due.pop_front();
               if (want.src_net !== rsp_data.src_net || want.dst_net !== rsp_data.dst_net ||
                   want.in_bytes !== rsp_data.in_bytes ||
                   want.out_bytes !== rsp_data.out_bytes) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("mismatch: exp src %0d dst %0d in %h out %h, got src %0d dst %0d in %h out %h",
                              want.src_net, want.dst_net, want.in_bytes, want.out_bytes,
                              rsp_data.src_net, rsp_data.dst_net, rsp_data.in_bytes,
                              rsp_data.out_bytes);
               end
            end
         end
      end
   end

   initial begin
      int i;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      mismatches   = 0;
      stuck_cycles = 0;
      calm         = 1'b0;
      hold_req     = 1'b0;
      for (i = 0; i < MAX_NETS; i++) begin
         cfg_base[i]   = '0;
         cfg_prefix[i] = '0;
      end
      for (i = 0; i < (MAX_NETS << DEF_HOST_BITS); i++) begin
         in_bytes_store[i]  = '0;
         out_bytes_store[i] = '0;
      end

      // all networks disabled after reset
      add_row(FUNC_PACKET, ETHERTYPE_IPV4, IP_VERSION_4, 32'hC0A8_0105, 32'hFFFF_FFFF,
              16'hFFFF, 2'd0, 8'd0, 1, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_READ, 16'hFFFF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 8'hFF,
              1, NO_NET, NO_NET, 32'd0, 32'd0);
      // net0 /24, net1 /32, net2 top /24, net3 base with host bits set
      add_row(FUNC_PACKET, ETHERTYPE_IPV4, IP_VERSION_4, 32'hC0A8_0105, 32'hFFFF_FFFF,
              16'hFFFF, 2'd0, 8'd0, 0, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_PACKET, 16'h86DD, IP_VERSION_4, 32'hC0A8_0105, 32'hC0A8_0105, 16'h1234,
              2'd0, 8'd0, 1, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_PACKET, ETHERTYPE_IPV4, 4'd6, 32'hC0A8_0105, 32'hC0A8_0105, 16'h1234,
              2'd0, 8'd0, 1, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_PACKET, ETHERTYPE_IPV4, 4'hF, 32'hC0A8_0105, 32'hC0A8_0105, 16'h1234,
              2'd0, 8'd0, 1, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_PACKET, 16'hF7FF, IP_VERSION_4, 32'hC0A8_0105, 32'hC0A8_0105, 16'h1234,
              2'd0, 8'd0, 1, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_PACKET, ETHERTYPE_IPV4, IP_VERSION_4, 32'h0A00_0000, 32'hC0A8_01FF,
              16'd100, 2'd0, 8'd0, 0, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_PACKET, ETHERTYPE_IPV4, IP_VERSION_4, 32'h0000_0001, 32'h0000_0000,
              16'h0000, 2'd0, 8'd0, 1, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_PACKET, ETHERTYPE_IPV4, IP_VERSION_4, 32'hFFFF_FF00, 32'hC0A8_0100,
              16'h0001, 2'd0, 8'd0, 0, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_READ, 16'd0, 4'd0, 32'd0, 32'd0, 16'd0, 2'd0, 8'd0,
              0, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_READ, 16'd0, 4'd0, 32'd0, 32'd0, 16'd0, 2'd0, 8'd5,
              1, NO_NET, NO_NET, 32'd0, 32'h0000_FFFF);
      add_row(FUNC_READ, 16'd0, 4'd0, 32'd0, 32'd0, 16'd0, 2'd0, 8'd5,
              1, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_READ, 16'd0, 4'd0, 32'd0, 32'd0, 16'd0, 2'd2, 8'hFF,
              0, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_READ, 16'd0, 4'd0, 32'd0, 32'd0, 16'd0, 2'd1, 8'd0,
              0, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_READ, 16'd0, 4'd0, 32'd0, 32'd0, 16'd0, 2'd1, 8'd7,
              1, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_READ, 16'd0, 4'd0, 32'd0, 32'd0, 16'd0, 2'd2, 8'd0,
              0, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_READ, 16'd0, 4'd0, 32'd0, 32'd0, 16'd0, 2'd0, 8'hFF,
              0, NO_NET, NO_NET, 32'd0, 32'd0);
      add_row(FUNC_PACKET, ETHERTYPE_IPV4, IP_VERSION_4, 32'h0A00_0001, 32'hFFFF_FF80,
              16'hFFFF, 2'd0, 8'd0, 0, NO_NET, NO_NET, 32'd0, 32'd0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < dir_rows.size(); i++) begin
         if (i == FIRST_CFG_ROW) begin
            next_base   = '{32'hC0A8_0100, 32'h0A00_0000, 32'hFFFF_FF00, 32'h0000_0001};
            next_prefix = '{6'd24, 6'd32, 6'd24, 6'd24};
            apply_setting();
         end
         offer_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].fixed);
      end

      run_random(140, 30, 90);

      // shrink net0 so reads land above its prefix; net2 overlaps net0; others disabled
      next_base   = '{32'hC0A8_0100, 32'h0A00_0000, 32'hC0A8_0100, 32'h0000_0000};
      next_prefix = '{6'd30, 6'd23, 6'd25, 6'd33};
      apply_setting();
      calm = 1'b1;
      run_random(60, -1, -1);
      calm = 1'b0;
      run_random(80, -1, -1);

      next_base   = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5670, 32'hAAAA_AA00};
      next_prefix = '{6'd32, 6'd24, 6'd28, 6'd63};
      apply_setting();
      run_random(130, -1, -1);

      random_setting();
      run_random(130, -1, -1);

      @(negedge clock);
      req_valid <= 1'b0;
      wait (counts_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && counts_due.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

/* sim.f */
sv/ipc_pkg.sv
sv/ipc_ctrl.sv
sv/ipc_datapath.sv
sv/ip_prefix_traffic_counter.sv
tb/sv/tb.sv
